// ===== rtl/core/ray_rectangle_hit_test_defines.svh =====
// ---------------------------------------------------------------------------
// Ray rectangle hit test assertion macros
// Shared wrappers for the concurrent checks of the hit test pipeline.
// ---------------------------------------------------------------------------
`ifndef RAY_RECTANGLE_HIT_TEST_DEFINES_SVH
`define RAY_RECTANGLE_HIT_TEST_DEFINES_SVH

// Check that is switched off while reset is asserted.
`define RRHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define RRHT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/rrht_pkg.sv =====
// ---------------------------------------------------------------------------
// Ray rectangle hit test package
// Shared types and constants of the hit test pipeline.
// ---------------------------------------------------------------------------
package rrht_pkg;

  // Default number of fraction bits of the fixed-point values.
  localparam int unsigned FracBitsDef = 16;

  // Width of every three-term dot product (two 33-bit factors, three terms).
  localparam int unsigned DotW = 68;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgOriginX   = 3'd0,
    CfgOriginY   = 3'd1,
    CfgOriginZ   = 3'd2,
    CfgDirX      = 3'd3,
    CfgDirY      = 3'd4,
    CfgDirZ      = 3'd5,
    CfgHalfWidth = 3'd6,
    CfgHalfHeight = 3'd7
  } cfg_reg_e;

  // Result codes.
  typedef enum logic [1:0] {
    MissNone     = 2'd0,
    MissParallel = 2'd1,
    MissBehind   = 2'd2,
    MissOutside  = 2'd3
  } miss_reason_e;

  // Three-component vector with room for a difference or a negation.
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } vec3_t;

  // Load enables of the two register banks inside a two-stage unit.
  typedef struct packed {
    logic first;
    logic second;
  } stage_en_t;

endpackage

// ===== rtl/core/rrht_mul.sv =====
// ---------------------------------------------------------------------------
// Ray rectangle hit test wide multiplier
// Signed WA x WB multiply split into 33x33 partial products, summed in a
// second register stage.
// ---------------------------------------------------------------------------
module rrht_mul #(
  parameter int unsigned WA = 68,
  parameter int unsigned WB = 68
) (
  input  logic                      clk_i,
  input  rrht_pkg::stage_en_t       en_i,
  input  logic signed [WA-1:0]      a_i,
  input  logic signed [WB-1:0]      b_i,
  output logic signed [WA+WB-1:0]   p_o
);

  localparam int unsigned NA = (WA + 31) / 32;
  localparam int unsigned NB = (WB + 31) / 32;
  localparam int unsigned WP = WA + WB;

  logic signed [NA*32-1:0] a_ext;
  logic signed [NB*32-1:0] b_ext;
  logic signed [65:0]      pp_d [NA][NB];
  logic signed [65:0]      pp_q [NA][NB];
  logic signed [WP-1:0]    p_d;
  logic signed [WP-1:0]    p_q;

  assign a_ext = (NA*32)'(a_i);
  assign b_ext = (NB*32)'(b_i);

  // Partial products: lower chunks are unsigned, the top chunk carries the sign.
  always_comb begin
    logic signed [32:0] ca;
    logic signed [32:0] cb;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        ca = (i == NA - 1) ? {a_ext[32*i+31], a_ext[32*i +: 32]}
                           : {1'b0, a_ext[32*i +: 32]};
        cb = (j == NB - 1) ? {b_ext[32*j+31], b_ext[32*j +: 32]}
                           : {1'b0, b_ext[32*j +: 32]};
        pp_d[i][j] = ca * cb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      pp_q <= pp_d;
    end
  end

  // Weighted sum of the partial products.
  always_comb begin
    p_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        p_d = p_d + (WP'(pp_q[i][j]) <<< (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.second) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/rrht_dot.sv =====
// ---------------------------------------------------------------------------
// Ray rectangle hit test dot product
// Three-term dot product: products in the first stage, sum in the second.
// ---------------------------------------------------------------------------
module rrht_dot (
  input  logic                                 clk_i,
  input  rrht_pkg::stage_en_t                  en_i,
  input  rrht_pkg::vec3_t                      a_i,
  input  rrht_pkg::vec3_t                      b_i,
  output logic signed [rrht_pkg::DotW-1:0]     dot_o
);
  import rrht_pkg::*;

  logic signed [65:0]     px_q;
  logic signed [65:0]     py_q;
  logic signed [65:0]     pz_q;
  logic signed [DotW-1:0] dot_q;

  // Component products.
  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      px_q <= a_i.x * b_i.x;
      py_q <= a_i.y * b_i.y;
      pz_q <= a_i.z * b_i.z;
    end
  end

  // Sum of the three products.
  always_ff @(posedge clk_i) begin
    if (en_i.second) begin
      dot_q <= DotW'(px_q) + DotW'(py_q) + DotW'(pz_q);
    end
  end

  assign dot_o = dot_q;

endmodule

// ===== rtl/core/ray_rectangle_hit_test.sv =====
// ---------------------------------------------------------------------------
// Ray rectangle hit test
// Tests one configured ray against a stream of placed rectangles.
// ---------------------------------------------------------------------------
// Usage: the ray origin, direction and the rectangle half sizes are written
// through the configuration port (write enable, index, data) while the block
// is idle. Each input transaction carries one rectangle placement (u, v and
// normal axes plus centre); each output transaction carries hit and the miss
// reason for that placement, in order.
// Pipeline: a result passes through nine register stages (input, offset,
// two dot product stages, two wide multiply stages, a second wide multiply
// pair, final compare).
// Throughput: one transaction per cycle while the receiver keeps ready high;
// every stage has its own valid bit and loads whenever the stage after it can take its content.
// Stall: when the receiver holds ready low the result stays in the output
// register and the stages behind it keep filling bubbles; ready at the input
// drops only when all nine stages hold items.
// Reset: all valid bits clear, origin and direction go to zero and both half
// sizes go to 32768, which is one half with the default 16 fraction bits.
// ---------------------------------------------------------------------------
`include "ray_rectangle_hit_test_defines.svh"

module ray_rectangle_hit_test #(
  parameter int unsigned FRAC_BITS = rrht_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] axis_u_x_i,
  input  logic signed [31:0] axis_u_y_i,
  input  logic signed [31:0] axis_u_z_i,
  input  logic signed [31:0] axis_v_x_i,
  input  logic signed [31:0] axis_v_y_i,
  input  logic signed [31:0] axis_v_z_i,
  input  logic signed [31:0] axis_n_x_i,
  input  logic signed [31:0] axis_n_y_i,
  input  logic signed [31:0] axis_n_z_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [1:0]         miss_reason_o
);
  import rrht_pkg::*;

  localparam int unsigned NumStages = 9;
  localparam int unsigned LhsW      = 2 * DotW + 1;
  localparam int unsigned Rhs1W     = DotW + 32;
  localparam int unsigned RhsW      = Rhs1W + DotW;
  localparam int unsigned CmpW      = (LhsW + FRAC_BITS > RhsW) ? LhsW + FRAC_BITS : RhsW;

  // Configuration registers.
  logic signed [31:0] org_x_q, org_y_q, org_z_q;
  logic signed [31:0] dir_x_q, dir_y_q, dir_z_q;
  logic [30:0]        half_w_q, half_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q  <= '0;
      org_y_q  <= '0;
      org_z_q  <= '0;
      dir_x_q  <= '0;
      dir_y_q  <= '0;
      dir_z_q  <= '0;
      half_w_q <= 31'd32768;
      half_h_q <= 31'd32768;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CfgOriginX:    org_x_q  <= cfg_wdata_i;
        CfgOriginY:    org_y_q  <= cfg_wdata_i;
        CfgOriginZ:    org_z_q  <= cfg_wdata_i;
        CfgDirX:       dir_x_q  <= cfg_wdata_i;
        CfgDirY:       dir_y_q  <= cfg_wdata_i;
        CfgDirZ:       dir_z_q  <= cfg_wdata_i;
        CfgHalfWidth:  half_w_q <= cfg_wdata_i[30:0];
        CfgHalfHeight: half_h_q <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage load enables.
  logic [NumStages:1]   v_q;
  logic [NumStages+1:1] en;

  always_comb begin
    en[NumStages+1] = out_ready_i;
    for (int k = NumStages; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = v_q[NumStages];

  // Stage 1: input registers.
  logic signed [31:0] u_x_q, u_y_q, u_z_q, av_x_q, av_y_q, av_z_q;
  logic signed [31:0] n_x_q, n_y_q, n_z_q, c_x_q, c_y_q, c_z_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      u_x_q  <= axis_u_x_i;
      u_y_q  <= axis_u_y_i;
      u_z_q  <= axis_u_z_i;
      av_x_q <= axis_v_x_i;
      av_y_q <= axis_v_y_i;
      av_z_q <= axis_v_z_i;
      n_x_q  <= axis_n_x_i;
      n_y_q  <= axis_n_y_i;
      n_z_q  <= axis_n_z_i;
      c_x_q  <= center_x_i;
      c_y_q  <= center_y_i;
      c_z_q  <= center_z_i;
    end
  end

  // Stage 2: offset from the centre to the origin and the negated normal.
  vec3_t w_q, nn_q, n2_q, u2_q, v2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      w_q.x  <= 33'(org_x_q) - 33'(c_x_q);
      w_q.y  <= 33'(org_y_q) - 33'(c_y_q);
      w_q.z  <= 33'(org_z_q) - 33'(c_z_q);
      nn_q.x <= -33'(n_x_q);
      nn_q.y <= -33'(n_y_q);
      nn_q.z <= -33'(n_z_q);
      n2_q   <= {33'(n_x_q), 33'(n_y_q), 33'(n_z_q)};
      u2_q   <= {33'(u_x_q), 33'(u_y_q), 33'(u_z_q)};
      v2_q   <= {33'(av_x_q), 33'(av_y_q), 33'(av_z_q)};
    end
  end

  // Stages 3 and 4: the eight dot products.
  vec3_t     d_vec;
  stage_en_t dot_en;
  logic signed [DotW-1:0] den, num, uw, ud, uu, vw, vd, vv;

  assign d_vec        = {33'(dir_x_q), 33'(dir_y_q), 33'(dir_z_q)};
  assign dot_en.first  = en[3];
  assign dot_en.second = en[4];

  rrht_dot u_dot_den (.clk_i, .en_i(dot_en), .a_i(d_vec), .b_i(n2_q),  .dot_o(den));
  rrht_dot u_dot_num (.clk_i, .en_i(dot_en), .a_i(w_q),   .b_i(nn_q),  .dot_o(num));
  rrht_dot u_dot_uw  (.clk_i, .en_i(dot_en), .a_i(u2_q),  .b_i(w_q),   .dot_o(uw));
  rrht_dot u_dot_ud  (.clk_i, .en_i(dot_en), .a_i(u2_q),  .b_i(d_vec), .dot_o(ud));
  rrht_dot u_dot_uu  (.clk_i, .en_i(dot_en), .a_i(u2_q),  .b_i(u2_q),  .dot_o(uu));
  rrht_dot u_dot_vw  (.clk_i, .en_i(dot_en), .a_i(v2_q),  .b_i(w_q),   .dot_o(vw));
  rrht_dot u_dot_vd  (.clk_i, .en_i(dot_en), .a_i(v2_q),  .b_i(d_vec), .dot_o(vd));
  rrht_dot u_dot_vv  (.clk_i, .en_i(dot_en), .a_i(v2_q),  .b_i(v2_q),  .dot_o(vv));

  // Stages 5 and 6: cross products of the plane test and the scaled bounds.
  stage_en_t m1_en;
  logic signed [2*DotW-1:0]  pu_a, pu_b, pv_a, pv_b;
  logic signed [Rhs1W-1:0]   qu, qv;
  logic signed [31:0]        hw_s, hh_s;

  assign m1_en.first  = en[5];
  assign m1_en.second = en[6];
  assign hw_s = {1'b0, half_w_q};
  assign hh_s = {1'b0, half_h_q};

  rrht_mul #(.WA(DotW), .WB(DotW)) u_mul_pua (.clk_i, .en_i(m1_en), .a_i(uw),  .b_i(den),
                                              .p_o(pu_a));
  rrht_mul #(.WA(DotW), .WB(DotW)) u_mul_pub (.clk_i, .en_i(m1_en), .a_i(num), .b_i(ud),
                                              .p_o(pu_b));
  rrht_mul #(.WA(DotW), .WB(DotW)) u_mul_pva (.clk_i, .en_i(m1_en), .a_i(vw),  .b_i(den),
                                              .p_o(pv_a));
  rrht_mul #(.WA(DotW), .WB(DotW)) u_mul_pvb (.clk_i, .en_i(m1_en), .a_i(num), .b_i(vd),
                                              .p_o(pv_b));
  rrht_mul #(.WA(DotW), .WB(32))   u_mul_qu  (.clk_i, .en_i(m1_en), .a_i(uu),  .b_i(hw_s),
                                              .p_o(qu));
  rrht_mul #(.WA(DotW), .WB(32))   u_mul_qv  (.clk_i, .en_i(m1_en), .a_i(vv),  .b_i(hh_s),
                                              .p_o(qv));

  // Early outcome flags and the magnitude of the denominator, carried along.
  logic                   par_q5, beh_q5, par_q6, beh_q6, par_q7, beh_q7, par_q8, beh_q8;
  logic signed [DotW-1:0] absd_q5, absd_q6;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      par_q5  <= (den == '0);
      beh_q5  <= (num != '0) && (num[DotW-1] != den[DotW-1]);
      absd_q5 <= den[DotW-1] ? -den : den;
    end
    if (en[6]) begin
      par_q6  <= par_q5;
      beh_q6  <= beh_q5;
      absd_q6 <= absd_q5;
    end
    if (en[7]) begin
      par_q7 <= par_q6;
      beh_q7 <= beh_q6;
    end
    if (en[8]) begin
      par_q8 <= par_q7;
      beh_q8 <= beh_q7;
    end
  end

  // Stages 7 and 8: right-hand bound times |D|.
  stage_en_t m2_en;
  logic signed [RhsW-1:0] ru, rv;

  assign m2_en.first  = en[7];
  assign m2_en.second = en[8];

  rrht_mul #(.WA(Rhs1W), .WB(DotW)) u_mul_ru (.clk_i, .en_i(m2_en), .a_i(qu), .b_i(absd_q6),
                                              .p_o(ru));
  rrht_mul #(.WA(Rhs1W), .WB(DotW)) u_mul_rv (.clk_i, .en_i(m2_en), .a_i(qv), .b_i(absd_q6),
                                              .p_o(rv));

  // Stage 7 sums the left-hand terms; stage 8 takes their magnitude.
  logic signed [LhsW-1:0] lu_q7, lv_q7;
  logic [LhsW-1:0]        lu_q8, lv_q8;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      lu_q7 <= LhsW'(pu_a) + LhsW'(pu_b);
      lv_q7 <= LhsW'(pv_a) + LhsW'(pv_b);
    end
    if (en[8]) begin
      lu_q8 <= lu_q7[LhsW-1] ? LhsW'(-lu_q7) : LhsW'(lu_q7);
      lv_q8 <= lv_q7[LhsW-1] ? LhsW'(-lv_q7) : LhsW'(lv_q7);
    end
  end

  // Stage 9: bound compares and the result register.
  logic [CmpW-1:0] cu_l, cv_l, cu_r, cv_r;
  logic            in_u, in_v;
  miss_reason_e    reason_d, reason_q;

  assign cu_l = CmpW'(lu_q8) << FRAC_BITS;
  assign cv_l = CmpW'(lv_q8) << FRAC_BITS;
  assign cu_r = CmpW'(unsigned'(ru));
  assign cv_r = CmpW'(unsigned'(rv));
  assign in_u = cu_l < cu_r;
  assign in_v = cv_l < cv_r;

  always_comb begin
    if (par_q8) begin
      reason_d = MissParallel;
    end else if (beh_q8) begin
      reason_d = MissBehind;
    end else if (in_u && in_v) begin
      reason_d = MissNone;
    end else begin
      reason_d = MissOutside;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      reason_q <= reason_d;
    end
  end

  assign miss_reason_o = reason_q;
  assign hit_o         = (reason_q == MissNone);

  // Assertions.
  `RRHT_ASSERT(a_ready_full, !in_ready_o |-> (&v_q) && !out_ready_i, "input stall, pipe not full")
  `RRHT_ASSERT(a_accept_enters, in_valid_i && in_ready_o |=> v_q[1], "transaction lost at entry")
  `RRHT_ASSERT_RST(a_reset_empty, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule
